/* rtl/lrcc_pkg.sv */
// ----------------------------------------------------------------------------
// lrcc_pkg
// Shared sizes, codes and types of the live register clobber checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lrcc_pkg;

    localparam int VREG_COUNT  = 256;
    localparam int REG_CLASSES = 4;
    localparam int LANES       = 64;
    localparam int ROWS        = (VREG_COUNT + LANES - 1) / LANES;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LANE_W      = 6;
    localparam int VREG_W      = 8;
    localparam int PHYS_W      = 6;
    localparam int CLASS_W     = 2;
    localparam int WIDX_W      = 2;
    localparam int WORD_W      = 64;
    localparam int ACTION_W    = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ASSIGN  = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_CLOBBER = 2'd2,
        ACT_USE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [PHYS_W-1:0]  phys;
        logic [CLASS_W-1:0] cls;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/live_register_clobber_checker.sv */
// ----------------------------------------------------------------------------
// live_register_clobber_checker
// Tracks live vregs and their register assignments, and reports the lowest
// live vreg of a class whose physical register an instruction overwrites.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | action, vreg, has_def, phys_num, assigned,
//          |                      | class_id, word_index, word_value,
//          |                      | clobber_mask
//  out     | out_valid / out_ready| clobber_found, victim_vreg, victim_reg,
//          |                      | failed
//
//  Assign, load and use words need no scan; their result is registered at
//  the accept edge. A clobber word of a valid class reads the entry memory
//  one 64-entry row per cycle, then a hit stage and a lowest-hit stage
//  follow; an invalid class skips the scan. One word is in flight at a time.
//  in_ready is low while a word is in flight or a result waits unaccepted.
//  Reset clears the live set, all assigned flags and the sticky flag.
// ----------------------------------------------------------------------------
`default_nettype none

module live_register_clobber_checker
    import lrcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [VREG_W-1:0]   vreg,
    input  wire logic                has_def,
    input  wire logic [PHYS_W-1:0]   phys_num,
    input  wire logic                assigned,
    input  wire logic [CLASS_W-1:0]  class_id,
    input  wire logic [WIDX_W-1:0]   word_index,
    input  wire logic [WORD_W-1:0]   word_value,
    input  wire logic [WORD_W-1:0]   clobber_mask,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     clobber_found,
    output logic [VREG_W-1:0]        victim_vreg,
    output logic [PHYS_W-1:0]        victim_reg,
    output logic                     failed
);

    state_t state_reg, state_next;

    logic [LANES-1:0] live_reg [ROWS];
    logic [LANES-1:0] held_reg [ROWS];
    entry_t [LANES-1:0] entry_mem [ROWS];
    entry_t [LANES-1:0] rd_data_reg;

    logic [ROW_W-1:0] issue_row_reg, issue_row_next;
    logic             issue_act_reg, issue_act_next;
    logic             rd_vld_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic             hit_vld_reg;
    logic [ROW_W-1:0] hit_row_reg;
    logic [LANES-1:0] hit_vec_reg, hit_vec_next;
    logic [LANES-1:0][PHYS_W-1:0] hit_phys_reg;

    logic               found_reg;
    logic [VREG_W-1:0]  victim_vreg_reg;
    logic [PHYS_W-1:0]  victim_phys_reg;
    logic [CLASS_W-1:0] item_cls_reg;
    logic [WORD_W-1:0]  item_mask_reg;
    logic               failure_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [VREG_W-1:0]  out_vreg_reg;
    logic [PHYS_W-1:0]  out_phys_reg;
    logic               out_failed_reg;

    logic              accept;
    logic              out_free;
    logic              vreg_ok;
    logic              widx_ok;
    logic              cls_ok;
    logic [ROW_W-1:0]  vreg_row;
    logic [LANE_W-1:0] vreg_lane;
    logic [ROW_W-1:0]  widx_row;
    logic              rd_en;
    logic              scan_start;
    logic              scan_skip;
    logic              scan_last;
    logic              finish_fire;
    logic              quick_fire;
    logic [LANE_W-1:0] low_idx;
    logic              take_hit;
    action_t           act;

    assign act       = action_t'(action);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign vreg_ok   = 32'(vreg) < VREG_COUNT;
    assign widx_ok   = 32'(word_index) < ROWS;
    assign cls_ok    = 32'(class_id) < REG_CLASSES;
    assign vreg_row  = ROW_W'(vreg >> LANE_W);
    assign vreg_lane = vreg[LANE_W-1:0];
    assign widx_row  = ROW_W'(word_index);

    assign scan_start  = accept && (act == ACT_CLOBBER) && cls_ok;
    assign scan_skip   = accept && (act == ACT_CLOBBER) && !cls_ok;
    assign quick_fire  = accept && (act != ACT_CLOBBER);
    assign scan_last   = hit_vld_reg && (hit_row_reg == ROW_W'(ROWS - 1));
    assign finish_fire = (state_reg == ST_FINISH) && out_free;
    assign take_hit    = hit_vld_reg && !found_reg && (|hit_vec_reg);

    always_comb
    begin
        state_next     = state_reg;
        issue_row_next = issue_row_reg;
        issue_act_next = issue_act_reg;
        rd_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (scan_start)
                begin
                    state_next     = ST_SCAN;
                    issue_row_next = '0;
                    issue_act_next = 1'b1;
                end
                else if (scan_skip)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (issue_act_reg)
                begin
                    rd_en          = 1'b1;
                    issue_row_next = issue_row_reg + 1'b1;
                    if (issue_row_reg == ROW_W'(ROWS - 1))
                    begin
                        issue_act_next = 1'b0;
                    end
                end
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            hit_vec_next[i] = live_reg[rd_row_reg][i] && held_reg[rd_row_reg][i]
                              && (rd_data_reg[i].cls == item_cls_reg)
                              && item_mask_reg[rd_data_reg[i].phys];
        end
    end

    always_comb
    begin
        low_idx = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                low_idx = LANE_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_row_reg <= '0;
            issue_act_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            hit_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            failure_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                live_reg[r] <= '0;
                held_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            issue_row_reg <= issue_row_next;
            issue_act_reg <= issue_act_next;
            rd_vld_reg    <= rd_en;
            hit_vld_reg   <= rd_vld_reg;

            if (accept)
            begin
                found_reg <= 1'b0;
            end
            else if (take_hit)
            begin
                found_reg <= 1'b1;
            end

            if (accept && (act == ACT_LOAD) && widx_ok)
            begin
                live_reg[widx_row] <= word_value;
            end
            if (accept && (act == ACT_CLOBBER) && has_def && vreg_ok)
            begin
                live_reg[vreg_row][vreg_lane] <= 1'b0;
            end
            if (accept && (act == ACT_USE) && vreg_ok)
            begin
                live_reg[vreg_row][vreg_lane] <= 1'b1;
            end
            if (accept && (act == ACT_ASSIGN) && vreg_ok)
            begin
                held_reg[vreg_row][vreg_lane] <= assigned;
            end

            if (finish_fire)
            begin
                failure_reg <= failure_reg || found_reg;
            end

            if (quick_fire || finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (act == ACT_ASSIGN) && vreg_ok)
        begin
            entry_mem[vreg_row][vreg_lane] <= '{phys: phys_num, cls: class_id};
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[issue_row_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= issue_row_reg;
        if (rd_vld_reg)
        begin
            hit_row_reg <= rd_row_reg;
            hit_vec_reg <= hit_vec_next;
            for (int i = 0; i < LANES; i++)
            begin
                hit_phys_reg[i] <= rd_data_reg[i].phys;
            end
        end

        if (accept)
        begin
            item_cls_reg    <= class_id;
            item_mask_reg   <= clobber_mask;
            victim_vreg_reg <= '0;
            victim_phys_reg <= '0;
        end
        else if (take_hit)
        begin
            victim_vreg_reg <= VREG_W'({hit_row_reg, low_idx});
            victim_phys_reg <= hit_phys_reg[low_idx];
        end

        if (quick_fire)
        begin
            out_found_reg  <= 1'b0;
            out_vreg_reg   <= '0;
            out_phys_reg   <= '0;
            out_failed_reg <= failure_reg;
        end
        else if (finish_fire)
        begin
            out_found_reg  <= found_reg;
            out_vreg_reg   <= victim_vreg_reg;
            out_phys_reg   <= victim_phys_reg;
            out_failed_reg <= failure_reg || found_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign clobber_found = out_found_reg;
    assign victim_vreg   = out_vreg_reg;
    assign victim_reg    = out_phys_reg;
    assign failed        = out_failed_reg;

endmodule

`default_nettype wire

/* rtl/lrcc_checker.sv */
// ----------------------------------------------------------------------------
// lrcc_checker
// Port-level checks of the live register clobber checker, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module lrcc_checker
    import lrcc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic                clobber_found,
    input wire logic [VREG_W-1:0]   victim_vreg,
    input wire logic [PHYS_W-1:0]   victim_reg,
    input wire logic                failed
);

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !clobber_found) |-> (victim_vreg == '0 && victim_reg == '0))
        else $error("victim fields nonzero without a hit");

    a_hit_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clobber_found) |-> failed)
        else $error("hit reported without failed set");

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |=> (!out_valid || failed))
        else $error("failed dropped");

    a_busy_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while a result is stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(clobber_found)
                                       && $stable(victim_vreg) && $stable(failed)))
        else $error("stalled result word changed");

endmodule

bind live_register_clobber_checker lrcc_checker u_lrcc_checker (.*);

`default_nettype wire
